/* rtl/cdas_pkg.sv */
`timescale 1ns / 1ps

package cdas_pkg;

  localparam logic [13:0] YearMin  = 14'd1900;
  localparam logic [13:0] YearMax  = 14'd9999;
  localparam logic [3:0]  MonthJan = 4'd1;
  localparam logic [3:0]  MonthDec = 4'd12;
  localparam logic [4:0]  DayFirst = 5'd1;
  localparam logic [4:0]  DayLast  = 5'd31;

  // Multiplicative inverse of 25 modulo 2^14. A year is a multiple of 25
  // exactly when its product with the inverse wraps to at most (2^14-1)/25.
  localparam logic [13:0] Inv25    = 14'd7209;
  localparam logic [13:0] Div25Max = 14'd655;

  typedef enum logic [1:0] {
    FUNC_SET = 2'd0,
    FUNC_ADD = 2'd1,
    FUNC_SUB = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_BACK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load_set;
    logic start_fwd;
    logic start_back;
    logic clear_flag;
    logic step_fwd;
    logic step_back;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fwd_done;
    logic back_done;
  } sts_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic        div25;
    logic        div4;
    logic        div16;
    prod  = {14'd0, y} * {14'd0, Inv25};
    div25 = (prod[13:0] <= Div25Max);
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    return (div4 && !div25) || (div16 && div25);
  endfunction

  // Days in month m of year y; zero for a month outside 1 to 12.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
    logic [4:0] len;
    case (m)
      4'd2: len = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

/* rtl/cdas_if.sv */
`timescale 1ns / 1ps

interface cdas_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] day_count;
  logic [13:0] set_year;
  logic [3:0]  set_month;
  logic [4:0]  set_day;

  modport source (output valid, func, day_count, set_year, set_month, set_day,
                  input ready);
  modport sink (input valid, func, day_count, set_year, set_month, set_day,
                output ready);
endinterface

interface cdas_rsp_if;
  logic        valid;
  logic        ready;
  logic [13:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic        fixed_up;

  modport source (output valid, cur_year, cur_month, cur_day, fixed_up,
                  input ready);
  modport sink (input valid, cur_year, cur_month, cur_day, fixed_up,
                output ready);
endinterface

/* rtl/cdas_ctrl.sv */
`timescale 1ns / 1ps

module cdas_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic [1:0]    req_func_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output cdas_pkg::cmd_t cmd_o,
  input  cdas_pkg::sts_t sts_i
);

  cdas_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             req_fire;
  logic             out_free;

  assign req_ready_o = (state_q == cdas_pkg::ST_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign out_free    = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cdas_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (cdas_pkg::func_e'(req_func_i))
            cdas_pkg::FUNC_ADD: state_d = cdas_pkg::ST_FWD;
            cdas_pkg::FUNC_SUB: state_d = cdas_pkg::ST_BACK;
            default:            state_d = cdas_pkg::ST_FIN;
          endcase
        end
      end
      cdas_pkg::ST_FWD: begin
        if (sts_i.fwd_done) state_d = cdas_pkg::ST_FIN;
      end
      cdas_pkg::ST_BACK: begin
        if (sts_i.back_done) state_d = cdas_pkg::ST_FIN;
      end
      cdas_pkg::ST_FIN: begin
        if (out_free) state_d = cdas_pkg::ST_IDLE;
      end
      default: state_d = cdas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      cdas_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (cdas_pkg::func_e'(req_func_i))
            cdas_pkg::FUNC_SET: cmd_o.load_set   = 1'b1;
            cdas_pkg::FUNC_ADD: cmd_o.start_fwd  = 1'b1;
            cdas_pkg::FUNC_SUB: cmd_o.start_back = 1'b1;
            default:            cmd_o.clear_flag = 1'b1;
          endcase
        end
      end
      cdas_pkg::ST_FWD:  cmd_o.step_fwd  = !sts_i.fwd_done;
      cdas_pkg::ST_BACK: cmd_o.step_back = !sts_i.back_done;
      cdas_pkg::ST_FIN:  cmd_o.emit      = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdas_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != cdas_pkg::ST_IDLE))
    else $error("accepted request did not start work");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> rsp_valid_o)
    else $error("emitted result not presented");
`endif

endmodule

/* rtl/cdas_dp.sv */
`timescale 1ns / 1ps

module cdas_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cdas_pkg::cmd_t cmd_i,
  output cdas_pkg::sts_t sts_o,
  input  logic [11:0]    day_count_i,
  input  logic [13:0]    set_year_i,
  input  logic [3:0]     set_month_i,
  input  logic [4:0]     set_day_i,
  output logic [13:0]    cur_year_o,
  output logic [3:0]     cur_month_o,
  output logic [4:0]     cur_day_o,
  output logic           fixed_up_o
);

  // Held date; the day is signed and wide so it can carry the running
  // day offset while a move walks month by month.
  logic [13:0]        y_q, y_d;
  logic [3:0]         m_q, m_d;
  logic signed [13:0] d_q, d_d;
  logic               flag_q, flag_d;

  logic [13:0] oy_q;
  logic [3:0]  om_q;
  logic [4:0]  od_q;
  logic        of_q;

  logic [4:0]         len_cur;
  logic [3:0]         m_prev;
  logic [13:0]        y_prev;
  logic [4:0]         len_prev;
  logic [4:0]         len_set;
  logic               set_bad;
  logic signed [13:0] len_cur_s;
  logic signed [13:0] len_prev_s;

  assign len_cur    = cdas_pkg::month_len(m_q, y_q);
  assign len_cur_s  = $signed({9'd0, len_cur});
  assign m_prev     = (m_q == cdas_pkg::MonthJan) ? cdas_pkg::MonthDec : m_q - 4'd1;
  assign y_prev     = (m_q == cdas_pkg::MonthJan) ? y_q - 14'd1 : y_q;
  assign len_prev   = cdas_pkg::month_len(m_prev, y_prev);
  assign len_prev_s = $signed({9'd0, len_prev});
  assign len_set    = cdas_pkg::month_len(set_month_i, set_year_i);
  assign set_bad    = (set_year_i < cdas_pkg::YearMin) || (set_year_i > cdas_pkg::YearMax) ||
                      (len_set == 5'd0) || (set_day_i == 5'd0) || (set_day_i > len_set);

  assign sts_o.fwd_done  = (d_q <= len_cur_s);
  assign sts_o.back_done = (d_q >= 14'sd1);

  always_comb begin
    y_d    = y_q;
    m_d    = m_q;
    d_d    = d_q;
    flag_d = flag_q;
    if (cmd_i.load_set) begin
      if (set_bad) begin
        y_d    = cdas_pkg::YearMin;
        m_d    = cdas_pkg::MonthJan;
        d_d    = $signed({9'd0, cdas_pkg::DayFirst});
        flag_d = 1'b1;
      end else begin
        y_d    = set_year_i;
        m_d    = set_month_i;
        d_d    = $signed({9'd0, set_day_i});
        flag_d = 1'b0;
      end
    end else if (cmd_i.start_fwd) begin
      d_d    = d_q + $signed({2'b00, day_count_i});
      flag_d = 1'b0;
    end else if (cmd_i.start_back) begin
      d_d    = d_q - $signed({2'b00, day_count_i});
      flag_d = 1'b0;
    end else if (cmd_i.clear_flag) begin
      flag_d = 1'b0;
    end else if (cmd_i.step_fwd) begin
      if (m_q == cdas_pkg::MonthDec) begin
        if (y_q == cdas_pkg::YearMax) begin
          // Walking past the last supported year pins the date there.
          m_d    = cdas_pkg::MonthDec;
          d_d    = $signed({9'd0, cdas_pkg::DayLast});
          flag_d = 1'b1;
        end else begin
          y_d = y_q + 14'd1;
          m_d = cdas_pkg::MonthJan;
          d_d = d_q - len_cur_s;
        end
      end else begin
        m_d = m_q + 4'd1;
        d_d = d_q - len_cur_s;
      end
    end else if (cmd_i.step_back) begin
      if ((m_q == cdas_pkg::MonthJan) && (y_q == cdas_pkg::YearMin)) begin
        // Walking before the first supported day pins the date there.
        d_d    = $signed({9'd0, cdas_pkg::DayFirst});
        flag_d = 1'b1;
      end else begin
        y_d = y_prev;
        m_d = m_prev;
        d_d = d_q + len_prev_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q    <= cdas_pkg::YearMin;
      m_q    <= cdas_pkg::MonthJan;
      d_q    <= $signed({9'd0, cdas_pkg::DayFirst});
      flag_q <= 1'b0;
    end else begin
      y_q    <= y_d;
      m_q    <= m_d;
      d_q    <= d_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      oy_q <= y_q;
      om_q <= m_q;
      od_q <= d_q[4:0];
      of_q <= flag_q;
    end
  end

  assign cur_year_o  = oy_q;
  assign cur_month_o = om_q;
  assign cur_day_o   = od_q;
  assign fixed_up_o  = of_q;

`ifndef SYNTHESIS
  a_emit_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> ((d_q >= 14'sd1) && (d_q <= 14'sd31)))
    else $error("result day outside 1 to 31");

  a_held_month_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_q >= cdas_pkg::MonthJan) && (m_q <= cdas_pkg::MonthDec) &&
    (y_q >= cdas_pkg::YearMin) && (y_q <= cdas_pkg::YearMax))
    else $error("held month or year out of range");
`endif

endmodule

/* rtl/calendar_date_add_subtract_days_top.sv */
`timescale 1ns / 1ps
// A set request, or one with the unused function code, needs no walk; an add or
// subtract first walks the held date one month per cycle until the day fits its month.
// One request is worked on at a time, and its result waits in the output register until taken.
// Reset (asynchronous, active low) holds 1900-1-1 and leaves no result pending.

module calendar_date_add_subtract_days_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  cdas_req_if.sink      req_i,
  cdas_rsp_if.source    rsp_o
);

  // The controller owns the handshakes and sequencing; the datapath owns the held
  // date, the month-length lookup and the result register.
  cdas_pkg::cmd_t cmd;
  cdas_pkg::sts_t sts;

  // The controller takes a new request only when idle. While a result is still
  // waiting in the output register, the next request can be accepted and walked;
  // it only stalls in its final state until the output register frees up.
  cdas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // On an add or subtract the datapath applies the day count to the held day in the accept
  // cycle and then moves one month per step until the day fits its month, clamping at the
  // ends of the supported range. Request fields are used only in the accept cycle.
  cdas_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .day_count_i (req_i.day_count),
    .set_year_i  (req_i.set_year),
    .set_month_i (req_i.set_month),
    .set_day_i   (req_i.set_day),
    .cur_year_o  (rsp_o.cur_year),
    .cur_month_o (rsp_o.cur_month),
    .cur_day_o   (rsp_o.cur_day),
    .fixed_up_o  (rsp_o.fixed_up)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

// Testbench for the Gregorian date register. A directed table comes first,
// followed by about a thousand random requests. Every accepted request is run
// through a calendar predictor in this file. Its expected date goes onto a
// queue, and the response monitor compares each response with it in order.
module testbench;

  // The function code that the block leaves unused. It must still answer with the
  // held date and a clear flag.
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam int NumRandom     = 1000;
  localparam int IdlePct       = 36;    // chance in 100 that a side idles in a cycle
  localparam int SteadyFirst   = 400;   // random requests in this window never idle
  localparam int SteadyLast    = 600;
  localparam int HoldOffAfter  = 150;   // responses taken before the long hold-off
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 200;   // longer than the longest walk
  localparam int WatchdogLimit = 5000;
  localparam int MaxReports    = 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] count;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_req_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        fixed_up;
  } date_rsp_t;

  // One row of the directed table. When typed is set, the expected response is
  // written out in the row. Otherwise the predictor supplies it.
  typedef struct {
    int func;
    int count;
    int year;
    int month;
    int day;
    int typed;
    int exp_year;
    int exp_month;
    int exp_day;
    int exp_flag;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  cdas_req_if req_if ();
  cdas_rsp_if rsp_if ();

  calendar_date_add_subtract_days_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // The date that the predictor holds. It tracks the block's register.
  logic [13:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;

  date_rsp_t pending_dates [$];
  int        fail_count;
  int        results_seen;
  bit        steady_send;

  // The directed rows. They cover the unused code right after reset, both ends
  // of the calendar range, clamping in each direction, every kind of invalid
  // date, leap-day corner cases, a zero day count and the largest day count.
  stim_row_t directed_rows [26] = '{
    '{FuncUnused,         0,    0,     0,  0,  1, 1900, 1,  1,  0},
    '{cdas_pkg::FUNC_SET, 0,    9999,  12, 31, 1, 9999, 12, 31, 0},
    '{cdas_pkg::FUNC_ADD, 1,    0,     0,  0,  1, 9999, 12, 31, 1},
    '{cdas_pkg::FUNC_SET, 0,    1900,  1,  1,  1, 1900, 1,  1,  0},
    '{cdas_pkg::FUNC_SUB, 1,    0,     0,  0,  1, 1900, 1,  1,  1},
    '{cdas_pkg::FUNC_SET, 0,    1899,  6,  15, 1, 1900, 1,  1,  1},
    '{cdas_pkg::FUNC_SET, 4095, 16383, 15, 31, 1, 1900, 1,  1,  1},
    '{cdas_pkg::FUNC_SET, 0,    2000,  2,  29, 1, 2000, 2,  29, 0},
    '{cdas_pkg::FUNC_SET, 0,    1900,  2,  29, 1, 1900, 1,  1,  1},
    '{cdas_pkg::FUNC_SET, 0,    2024,  2,  30, 1, 1900, 1,  1,  1},
    '{cdas_pkg::FUNC_SET, 0,    2023,  4,  0,  1, 1900, 1,  1,  1},
    '{cdas_pkg::FUNC_SET, 0,    2023,  0,  10, 1, 1900, 1,  1,  1},
    '{cdas_pkg::FUNC_SET, 0,    2023,  6,  15, 1, 2023, 6,  15, 0},
    '{cdas_pkg::FUNC_ADD, 0,    0,     0,  0,  1, 2023, 6,  15, 0},
    '{cdas_pkg::FUNC_ADD, 4095, 0,     0,  0,  0, 0,    0,  0,  0},
    '{cdas_pkg::FUNC_SUB, 4095, 0,     0,  0,  0, 0,    0,  0,  0},
    '{cdas_pkg::FUNC_SUB, 0,    0,     0,  0,  0, 0,    0,  0,  0},
    '{FuncUnused,         4095, 16383, 15, 31, 0, 0,    0,  0,  0},
    '{cdas_pkg::FUNC_SET, 0,    9990,  1,  1,  1, 9990, 1,  1,  0},
    '{cdas_pkg::FUNC_ADD, 4095, 0,     0,  0,  1, 9999, 12, 31, 1},
    '{cdas_pkg::FUNC_SET, 0,    1905,  6,  1,  1, 1905, 6,  1,  0},
    '{cdas_pkg::FUNC_SUB, 4095, 0,     0,  0,  1, 1900, 1,  1,  1},
    '{cdas_pkg::FUNC_SET, 0,    2100,  2,  28, 1, 2100, 2,  28, 0},
    '{cdas_pkg::FUNC_ADD, 1,    0,     0,  0,  0, 0,    0,  0,  0},
    '{cdas_pkg::FUNC_SET, 0,    2000,  3,  1,  1, 2000, 3,  1,  0},
    '{cdas_pkg::FUNC_SUB, 1,    0,     0,  0,  0, 0,    0,  0,  0}
  };

  function automatic bit gregorian_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Gives the number of days in a month, or zero when the month number is not valid.
  function automatic int days_in_month(input int m, input int y);
    case (m)
      2:                       return gregorian_leap(y) ? 29 : 28;
      4, 6, 9, 11:             return 30;
      1, 3, 5, 7, 8, 10, 12:   return 31;
      default:                 return 0;
    endcase
  endfunction

  // Applies one request to the predicted date and returns the response that it
  // should produce. Moves go one month at a time. Each move stops at the edge of
  // the range and raises the flag when it would leave 1900-1-1 .. 9999-12-31.
  function automatic date_rsp_t advance_calendar(input date_req_t r);
    int        yr;
    int        mo;
    int        dy;
    int        len;
    logic      clamped;
    date_rsp_t res;
    clamped = 1'b0;
    yr = cal_year;
    mo = cal_month;
    dy = cal_day;
    case (r.func)
      cdas_pkg::FUNC_SET: begin
        len = days_in_month(r.month, r.year);
        if (r.year < cdas_pkg::YearMin || r.year > cdas_pkg::YearMax || len == 0 ||
            r.day == 0 || r.day > len) begin
          clamped = 1'b1;
          yr = cdas_pkg::YearMin;
          mo = cdas_pkg::MonthJan;
          dy = cdas_pkg::DayFirst;
        end else begin
          yr = r.year;
          mo = r.month;
          dy = r.day;
        end
      end
      cdas_pkg::FUNC_ADD: begin
        dy = dy + r.count;
        while (!clamped && dy > days_in_month(mo, yr)) begin
          dy = dy - days_in_month(mo, yr);
          mo++;
          if (mo > cdas_pkg::MonthDec) begin
            mo = cdas_pkg::MonthJan;
            yr++;
            if (yr > cdas_pkg::YearMax) clamped = 1'b1;
          end
        end
        if (clamped) begin
          yr = cdas_pkg::YearMax;
          mo = cdas_pkg::MonthDec;
          dy = cdas_pkg::DayLast;
        end
      end
      cdas_pkg::FUNC_SUB: begin
        dy = dy - r.count;
        while (!clamped && dy < 1) begin
          if (mo <= cdas_pkg::MonthJan) begin
            mo = cdas_pkg::MonthDec;
            if (yr <= cdas_pkg::YearMin) clamped = 1'b1;
            else yr--;
          end else begin
            mo--;
          end
          if (!clamped) dy = dy + days_in_month(mo, yr);
        end
        if (clamped) begin
          yr = cdas_pkg::YearMin;
          mo = cdas_pkg::MonthJan;
          dy = cdas_pkg::DayFirst;
        end
      end
      default: ;
    endcase
    cal_year  = yr[13:0];
    cal_month = mo[3:0];
    cal_day   = dy[4:0];
    res.year     = cal_year;
    res.month    = cal_month;
    res.day      = cal_day;
    res.fixed_up = clamped;
    return res;
  endfunction

  // Draws one random request. Most sets load valid dates, and half of those
  // fall in the first or last years of the range so that moves run into the
  // clamps often. The remaining sets use raw field values. Add and subtract
  // requests also put noise on the set fields, which the block ignores for them.
  function automatic date_req_t random_request();
    date_req_t r;
    int        pick;
    pick = $urandom_range(99);
    r.year  = 14'($urandom_range(16383));
    r.month = 4'($urandom_range(15));
    r.day   = 5'($urandom_range(31));
    r.count = ($urandom_range(3) == 0) ? 12'($urandom_range(40)) : 12'($urandom_range(4095));
    if (pick < 30) begin
      r.func = cdas_pkg::FUNC_SET;
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(3))
          0:       r.year = 14'(cdas_pkg::YearMin + $urandom_range(15));
          1:       r.year = 14'(cdas_pkg::YearMax - $urandom_range(15));
          default: r.year = 14'($urandom_range(cdas_pkg::YearMax, cdas_pkg::YearMin));
        endcase
        r.month = 4'($urandom_range(cdas_pkg::MonthDec, cdas_pkg::MonthJan));
        r.day   = 5'($urandom_range(days_in_month(r.month, r.year), 1));
      end
    end else if (pick < 62) begin
      r.func = cdas_pkg::FUNC_ADD;
    end else if (pick < 94) begin
      r.func = cdas_pkg::FUNC_SUB;
    end else begin
      r.func = FuncUnused;
    end
    return r;
  endfunction

  // Offers one request at the falling edge. An idle gap of random length may
  // come first. The task returns at the falling edge after the request is
  // taken, so each cycle sees no more than one write to valid.
  task automatic send_request(input date_req_t r, input date_rsp_t expected);
    while (!steady_send && $urandom_range(99) < IdlePct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.func      = r.func;
    req_if.day_count = r.count;
    req_if.set_year  = r.year;
    req_if.set_month = r.month;
    req_if.set_day   = r.day;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_dates.push_back(expected);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Runs the stimulus: reset first, then the directed table and the random
  // requests, and at the end a drain of the outstanding responses.
  initial begin
    date_req_t r;
    date_rsp_t expected;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = cdas_pkg::FUNC_SET;
    req_if.day_count = '0;
    req_if.set_year  = '0;
    req_if.set_month = '0;
    req_if.set_day   = '0;
    steady_send      = 1'b0;
    cal_year         = cdas_pkg::YearMin;
    cal_month        = cdas_pkg::MonthJan;
    cal_day          = cdas_pkg::DayFirst;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      r.func  = directed_rows[i].func[1:0];
      r.count = directed_rows[i].count[11:0];
      r.year  = directed_rows[i].year[13:0];
      r.month = directed_rows[i].month[3:0];
      r.day   = directed_rows[i].day[4:0];
      // The predictor runs on every row so that its date keeps in step with the block.
      expected = advance_calendar(r);
      if (directed_rows[i].typed != 0) begin
        expected.year     = directed_rows[i].exp_year[13:0];
        expected.month    = directed_rows[i].exp_month[3:0];
        expected.day      = directed_rows[i].exp_day[4:0];
        expected.fixed_up = directed_rows[i].exp_flag[0];
      end
      send_request(r, expected);
    end

    for (int n = 0; n < NumRandom; n++) begin
      steady_send = (n >= SteadyFirst && n < SteadyLast);
      r = random_request();
      send_request(r, advance_calendar(r));
    end
    req_if.valid = 1'b0;

    while (pending_dates.size() != 0) @(posedge clk_i);
    // A late extra response would still be seen by the monitor in this window.
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Drives ready on the response side. Ready idles at random, except in a
  // stretch where it never idles. After HoldOffAfter responses it is held low
  // for a long stretch. That backs the block up, and it then has to stall the
  // requests that keep coming.
  initial begin
    bit held_off;
    held_off     = 1'b0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!held_off && results_seen >= HoldOffAfter) begin
        held_off     = 1'b1;
        rsp_if.ready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      if (results_seen >= SteadyFirst + 50 && results_seen < SteadyLast + 50) begin
        rsp_if.ready = 1'b1;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= IdlePct);
      end
      @(negedge clk_i);
    end
  end

  // Checks every response against the oldest expected date.
  initial begin
    date_rsp_t expected;
    fail_count   = 0;
    results_seen = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (pending_dates.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("[%0t] unexpected response %0d-%0d-%0d fixed_up=%0b", $realtime,
                     rsp_if.cur_year, rsp_if.cur_month, rsp_if.cur_day, rsp_if.fixed_up);
          end
        end else begin
          expected = pending_dates.pop_front();
          if (rsp_if.cur_year !== expected.year || rsp_if.cur_month !== expected.month ||
              rsp_if.cur_day !== expected.day || rsp_if.fixed_up !== expected.fixed_up) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("[%0t] response %0d: exp %0d-%0d-%0d/%0b got %0d-%0d-%0d/%0b",
                       $realtime, results_seen, expected.year, expected.month, expected.day,
                       expected.fixed_up, rsp_if.cur_year, rsp_if.cur_month, rsp_if.cur_day,
                       rsp_if.fixed_up);
            end
          end
        end
      end
    end
  end

  // Ends the run when no request and no response has moved for too long. The
  // limit allows for the longest walk, the hold-off and the final drain.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* calendar_date_add_subtract_days_top.f */
rtl/cdas_pkg.sv
rtl/cdas_if.sv
rtl/cdas_ctrl.sv
rtl/cdas_dp.sv
rtl/calendar_date_add_subtract_days_top.sv
verif/testbench.sv
